// ===== hw/rtl/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and constants for the UTF-8 decoder
// Item structs, the per-byte result batch, and byte classification helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

	localparam int BYTE_W  = 8;
	localparam int CP_W    = 21;
	localparam int MAX_RES = 3;
	localparam int CNT_W   = $clog2(MAX_RES + 1);
	localparam int IDX_W   = $clog2(MAX_RES);

	localparam logic [BYTE_W-1:0] ASCII_LIM  = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD1_MASK = 8'he0;
	localparam logic [BYTE_W-1:0] LEAD1_CODE = 8'hc0;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hf0;
	localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'he0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hf8;
	localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hf0;
	localparam logic [BYTE_W-1:0] LEAD1_BITS = 8'h1f;
	localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h0f;
	localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h07;
	localparam int                PAY_W      = 6;  // payload bits per trailing byte (0x3f)

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              in_last;
	} in_item_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            run_end;
	} out_item_t;

	// results caused by one byte, oldest in entry 0
	typedef struct packed {
		logic [CNT_W-1:0]              cnt;
		logic [MAX_RES-1:0][CP_W-1:0]  cp;
	} batch_t;

	typedef struct packed {
		logic       seq_open;
		logic [1:0] bytes_seen;
	} core_sts_t;

	typedef enum logic [2:0] {
		CLS_ASCII,
		CLS_LEAD1,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_STRAY
	} byte_cls_t;

	function automatic byte_cls_t classify(input logic [BYTE_W-1:0] b);
		byte_cls_t c;
		if (b < ASCII_LIM)                      c = CLS_ASCII;
		else if ((b & LEAD1_MASK) == LEAD1_CODE) c = CLS_LEAD1;
		else if ((b & LEAD2_MASK) == LEAD2_CODE) c = CLS_LEAD2;
		else if ((b & LEAD3_MASK) == LEAD3_CODE) c = CLS_LEAD3;
		else                                    c = CLS_STRAY;
		return c;
	endfunction

	// trailing bytes a lead asks for
	function automatic logic [1:0] cls_need(input byte_cls_t c);
		logic [1:0] n;
		case (c)
			CLS_LEAD1: n = 2'd1;
			CLS_LEAD2: n = 2'd2;
			CLS_LEAD3: n = 2'd3;
			default:   n = 2'd0;
		endcase
		return n;
	endfunction

	// value bits carried by a lead byte
	function automatic logic [CP_W-1:0] lead_bits(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] v;
		case (classify(b))
			CLS_LEAD1: v = b & LEAD1_BITS;
			CLS_LEAD2: v = b & LEAD2_BITS;
			CLS_LEAD3: v = b & LEAD3_BITS;
			default:   v = '0;
		endcase
		return CP_W'(v);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/u8d_core.sv =====
// ----------------------------------------------------------------------------
// u8d_core: sequence state and per-byte decode
// Builds the result batch for the byte in the input stage and updates the
// open-sequence state when that byte moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire u8d_pkg::in_item_t  item,
	input  wire logic               fire,
	output u8d_pkg::batch_t         batch,
	output u8d_pkg::core_sts_t      sts
);
	import u8d_pkg::*;

	logic [1:0]        et_q, et_d;     // trailing bytes the open sequence needs
	logic [1:0]        bs_q, bs_d;     // trailing bytes taken so far
	logic [CP_W-1:0]   pv_q, pv_d;     // value assembled so far
	logic [BYTE_W-1:0] held_q, held_d; // first trailing byte, for a rescan

	always_comb begin
		byte_cls_t         cls_b;
		byte_cls_t         cls_h;
		logic [CP_W-1:0]   pv_sh;
		logic [CNT_W-1:0]  n;
		logic              tail;
		logic [BYTE_W-1:0] b;

		b     = item.in_byte;
		cls_b = classify(b);
		cls_h = classify(held_q);
		pv_sh = {pv_q[CP_W-PAY_W-1:0], b[PAY_W-1:0]};
		n     = '0;
		tail  = 1'b1;
		et_d  = et_q;
		bs_d  = bs_q;
		pv_d  = pv_q;
		held_d = held_q;
		batch.cp = '0;

		if (et_q == 2'd0) begin
			case (cls_b)
				CLS_ASCII: begin
					batch.cp[IDX_W'(n)] = CP_W'(b);
					n = n + 1'b1;
				end
				CLS_LEAD1, CLS_LEAD2, CLS_LEAD3: begin
					if (item.in_last) begin
						batch.cp[IDX_W'(n)] = '0;
						n = n + 1'b1;
					end else begin
						et_d = cls_need(cls_b);
						bs_d = 2'd0;
						pv_d = lead_bits(b);
					end
				end
				default: begin
				end
			endcase
		end else begin
			pv_d = pv_sh;
			if (bs_q == et_q - 2'd1) begin
				batch.cp[IDX_W'(n)] = pv_sh;
				n = n + 1'b1;
				et_d = 2'd0;
				bs_d = 2'd0;
			end else if (item.in_last) begin
				// cut off: zero for the lead, then decode the held bytes afresh
				batch.cp[IDX_W'(n)] = '0;
				n = n + 1'b1;
				et_d = 2'd0;
				bs_d = 2'd0;
				if (bs_q != 2'd0) begin
					case (cls_h)
						CLS_ASCII: begin
							batch.cp[IDX_W'(n)] = CP_W'(held_q);
							n = n + 1'b1;
						end
						CLS_LEAD1: begin
							// two-byte form completes with the final byte
							batch.cp[IDX_W'(n)] =
								CP_W'({held_q[4:0], b[PAY_W-1:0]});
							n = n + 1'b1;
							tail = 1'b0;
						end
						CLS_LEAD2, CLS_LEAD3: begin
							batch.cp[IDX_W'(n)] = '0;
							n = n + 1'b1;
						end
						default: begin
						end
					endcase
				end
				if (tail) begin
					case (cls_b)
						CLS_ASCII: begin
							batch.cp[IDX_W'(n)] = CP_W'(b);
							n = n + 1'b1;
						end
						CLS_LEAD1, CLS_LEAD2, CLS_LEAD3: begin
							batch.cp[IDX_W'(n)] = '0;
							n = n + 1'b1;
						end
						default: begin
						end
					endcase
				end
			end else begin
				if (bs_q == 2'd0) begin
					held_d = b;
				end
				bs_d = bs_q + 2'd1;
			end
		end
		batch.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			et_q <= 2'd0;
			bs_q <= 2'd0;
			pv_q <= '0;
		end else if (fire) begin
			et_q <= et_d;
			bs_q <= bs_d;
			pv_q <= pv_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			held_q <= held_d;
		end
	end

	assign sts.seq_open   = (et_q != 2'd0);
	assign sts.bytes_seen = bs_q;

endmodule

`default_nettype wire

// ===== hw/rtl/u8d_out_buf.sv =====
// ----------------------------------------------------------------------------
// u8d_out_buf: result register
// Holds one byte's batch of results and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_out_buf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire u8d_pkg::batch_t    batch,
	output logic                    free,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output u8d_pkg::out_item_t      out_item
);
	import u8d_pkg::*;

	batch_t            batch_q;
	logic              bvalid_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic              last_rd;

	assign last_rd = (CNT_W'(rd_idx_q) == batch_q.cnt - CNT_W'(1));
	assign free    = !bvalid_q || (out_ready && last_rd);

	assign out_valid           = bvalid_q;
	assign out_item.code_point = batch_q.cp[rd_idx_q];
	assign out_item.run_end    = last_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= 1'b0;
			rd_idx_q <= '0;
		end else if (load) begin
			bvalid_q <= 1'b1;
			rd_idx_q <= '0;
		end else if (bvalid_q && out_ready) begin
			if (last_rd) begin
				bvalid_q <= 1'b0;
			end else begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			batch_q <= batch;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_to_codepoint_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder: UTF-8 byte stream to code points
// One byte per request in, one code point per request out.
// ----------------------------------------------------------------------------
//
//   channel | signals                        | carries
//   --------+--------------------------------+----------------------------------
//   in      | in_valid, in_ready, in_item    | in_byte, in_last
//   out     | out_valid, out_ready, out_item | code_point, run_end
//
// A byte is taken every cycle while each byte yields at most one code point
// and the output is not stalled; a byte that yields k code points (k up to 3
// at a cut-off end of stream) keeps the result register busy until all k have
// gone out, one code point per cycle while out_ready holds. A code point passes
// through the input stage, then the result register. Reset clears the stage valids and the sequence state.
// A stalled output holds the result register; the input stage keeps one
// byte and in_ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_codepoint_decoder (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire u8d_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output u8d_pkg::out_item_t      out_item
);
	import u8d_pkg::*;

	// input stage
	logic       valid_s1;
	in_item_t   item_s1;

	batch_t     batch;      // results of the byte in the input stage
	core_sts_t  sts;
	logic       buf_free;   // result register can take a batch this cycle
	logic       adv;        // input stage byte moves on this cycle

	// a byte with no result needs no room in the result register
	assign adv      = valid_s1 && ((batch.cnt == '0) || buf_free);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	u8d_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (adv),
		.batch  (batch),
		.sts    (sts)
	);

	u8d_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && (batch.cnt != '0)),
		.batch     (batch),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

`ifndef SYNTHESIS
	// a blocked input stage keeps its byte
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost or changed a blocked byte");

	// the end of a stream always closes the sequence
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.in_last |=> !sts.seq_open)
		else $error("sequence still open after final byte");

	// no trailing bytes counted without an open sequence
	a_closed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!sts.seq_open |-> sts.bytes_seen == 2'd0)
		else $error("byte count set with no open sequence");

	// a batch never lands on results still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (batch.cnt != '0) |-> buf_free)
		else $error("result register overwritten");
`endif

endmodule

`default_nettype wire
